// File: rtl/core/stl_pkg.sv
package stl_pkg;

    // Run counter width and saturation limit
    localparam int RunCountWidth = 16;
    localparam logic [15:0] SpaceLimit = (RunCountWidth >= 16) ? 16'hFFFF :
        16'((32'd1 << RunCountWidth) - 32'd1);

    // Record queue between front and back
    localparam int QueueDepth = 4;
    localparam int QueuePtrWidth = $clog2(QueueDepth);
    localparam int QueueCntWidth = $clog2(QueueDepth + 1);

    // Configuration port
    localparam int CfgAddrWidth = 2;
    localparam logic [CfgAddrWidth-1:0] AddrWhitespaceMode = 2'd0;

    // Token kinds
    localparam logic [2:0] KindChar    = 3'd0;
    localparam logic [2:0] KindNewline = 3'd1;
    localparam logic [2:0] KindTab     = 3'd2;
    localparam logic [2:0] KindSpace   = 3'd3;
    localparam logic [2:0] KindGroup   = 3'd4;
    localparam logic [2:0] KindNumber  = 3'd5;
    localparam logic [2:0] KindString  = 3'd6;
    localparam logic [2:0] KindIdent   = 3'd7;

    // Whitespace modes
    localparam logic [1:0] WsLiteral  = 2'd0;
    localparam logic [1:0] WsRaw      = 2'd1;
    localparam logic [1:0] WsSuppress = 2'd2;
    localparam logic [1:0] WsGroup    = 2'd3;

    // Lexer states
    localparam logic [2:0] LexIdle  = 3'd0;
    localparam logic [2:0] LexNum   = 3'd1;
    localparam logic [2:0] LexIdent = 3'd2;
    localparam logic [2:0] LexStr   = 3'd3;
    localparam logic [2:0] LexSpace = 3'd4;
    localparam logic [2:0] LexDrop  = 3'd5;

    // Characters
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChDot       = 8'h2E;
    localparam logic [7:0] ChUnderscore = 8'h5F;
    localparam logic [7:0] ChNewline   = 8'h0A;
    localparam logic [7:0] ChTab       = 8'h09;
    localparam logic [7:0] ChSpace     = 8'h20;
    localparam logic [7:0] ChDquote    = 8'h22;
    localparam logic [7:0] ChSquote    = 8'h27;
    localparam logic [7:0] ChNul       = 8'h00;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } text_in_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  token_byte;
        logic        token_start;
        logic [15:0] space_run;
        logic        step_last;
    } token_out_t;

    // All results of one byte: one or two items
    typedef struct packed {
        token_out_t item_a;
        token_out_t item_b;
        logic       two;
    } step_rec_t;

endpackage

// File: rtl/core/source_text_lexer.sv
// A byte accepted at a clock edge writes its step record, if it has results, into the queue at that edge.
// Throughput: one byte per cycle while the queue is not full; a byte with two results needs two pops.
// Four step records queue between the classifier and the result serializer.
// Reset (rst_n low, asynchronous): lexer idle, queue empty, whitespace_mode = 0.
module source_text_lexer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  stl_pkg::text_in_t                 item,
    output logic                              empty,
    input  logic                              pop,
    output stl_pkg::token_out_t               result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stl_pkg::CfgAddrWidth-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic [1:0]          whitespace_mode_reg;
    logic                accept;
    logic                rec_valid;
    logic                rd_en;
    logic                q_empty, q_full;
    stl_pkg::step_rec_t  rec, head;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == stl_pkg::AddrWhitespaceMode) ?
                    {30'd0, whitespace_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            whitespace_mode_reg <= stl_pkg::WsLiteral;
        else if (psel && penable && pwrite && pready
                 && (paddr == stl_pkg::AddrWhitespaceMode))
            whitespace_mode_reg <= pwdata[1:0];
    end

    // Input transfer
    assign full   = q_full;
    assign accept = push && !q_full;
    assign empty  = q_empty;

    stl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .accept    (accept),
        .ws_mode   (whitespace_mode_reg),
        .rec       (rec),
        .rec_valid (rec_valid)
    );

    stl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_rec  (rec),
        .rd_en   (rd_en),
        .rd_rec  (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    stl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .rd_en   (rd_en),
        .result  (result)
    );

endmodule

// File: rtl/core/stl_front.sv
module stl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stl_pkg::text_in_t    item,
    input  logic                 accept,
    input  logic [1:0]           ws_mode,
    output stl_pkg::step_rec_t   rec,
    output logic                 rec_valid
);

    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  quote_reg, quote_next;
    logic        esc_reg, esc_next;
    logic [15:0] cnt_reg, cnt_next;

    logic [7:0]  b;
    logic        le;
    logic        is_digit, is_alpha, is_ws;
    logic [2:0]  ws_kind;

    logic        pre_valid, fresh_valid, end_valid, handled;
    stl_pkg::token_out_t pre_item, fresh_item, end_item;

    function automatic stl_pkg::token_out_t make_item(
        input logic [2:0] kind, input logic [7:0] byte_v, input logic start);
        stl_pkg::token_out_t t;
        t.token_kind  = kind;
        t.token_byte  = byte_v;
        t.token_start = start;
        t.space_run   = 16'd0;
        t.step_last   = 1'b0;
        return t;
    endfunction

    function automatic stl_pkg::token_out_t make_flush(input logic [15:0] cnt);
        stl_pkg::token_out_t t;
        if (cnt >= 16'd2)
        begin
            t.token_kind = stl_pkg::KindGroup;
            t.token_byte = 8'd0;
            t.space_run  = cnt;
        end
        else
        begin
            t.token_kind = stl_pkg::KindSpace;
            t.token_byte = stl_pkg::ChSpace;
            t.space_run  = 16'd0;
        end
        t.token_start = 1'b1;
        t.step_last   = 1'b0;
        return t;
    endfunction

    assign b  = item.text_byte;
    assign le = item.line_end;

    // Byte classes
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    assign is_ws    = (b == stl_pkg::ChNewline) || (b == stl_pkg::ChTab)
                   || (b == stl_pkg::ChSpace);
    assign ws_kind  = (b == stl_pkg::ChNewline) ? stl_pkg::KindNewline :
                      (b == stl_pkg::ChTab) ? stl_pkg::KindTab : stl_pkg::KindSpace;

    // One lexer step: line drop, zero byte, continuation, fresh token, end-of-line close
    always_comb
    begin
        mode_next   = mode_reg;
        quote_next  = quote_reg;
        esc_next    = esc_reg;
        cnt_next    = cnt_reg;
        pre_valid   = 1'b0;
        fresh_valid = 1'b0;
        end_valid   = 1'b0;
        handled     = 1'b0;
        pre_item    = '0;
        fresh_item  = '0;
        end_item    = '0;

        if (mode_reg == stl_pkg::LexDrop)
        begin
            if (le)
            begin
                mode_next  = stl_pkg::LexIdle;
                quote_next = 8'd0;
                esc_next   = 1'b0;
                cnt_next   = 16'd0;
            end
        end
        else if (b == stl_pkg::ChNul)
        begin
            if (mode_reg == stl_pkg::LexSpace)
            begin
                pre_valid = 1'b1;
                pre_item  = make_flush(cnt_reg);
            end
            mode_next  = le ? stl_pkg::LexIdle : stl_pkg::LexDrop;
            quote_next = 8'd0;
            esc_next   = 1'b0;
            cnt_next   = 16'd0;
        end
        else
        begin
            // continue an open token
            case (mode_reg)
                stl_pkg::LexSpace:
                begin
                    if (b == stl_pkg::ChSpace)
                    begin
                        if (cnt_reg < stl_pkg::SpaceLimit)
                            cnt_next = cnt_reg + 16'd1;
                        handled = 1'b1;
                    end
                    else
                    begin
                        pre_valid = 1'b1;
                        pre_item  = make_flush(cnt_reg);
                        cnt_next  = 16'd0;
                        mode_next = stl_pkg::LexIdle;
                    end
                end
                stl_pkg::LexStr:
                begin
                    pre_valid = 1'b1;
                    pre_item  = make_item(stl_pkg::KindString, b, 1'b0);
                    handled   = 1'b1;
                    if (b == stl_pkg::ChBackslash)
                        esc_next = ~esc_reg;
                    else if ((b == quote_reg) && !esc_reg)
                    begin
                        mode_next  = stl_pkg::LexIdle;
                        quote_next = 8'd0;
                    end
                    else
                        esc_next = 1'b0;
                end
                stl_pkg::LexNum:
                begin
                    if (is_digit || is_alpha || (b == stl_pkg::ChDot))
                    begin
                        pre_valid = 1'b1;
                        pre_item  = make_item(stl_pkg::KindNumber, b, 1'b0);
                        handled   = 1'b1;
                    end
                end
                stl_pkg::LexIdent:
                begin
                    if (is_alpha || (b == stl_pkg::ChUnderscore))
                    begin
                        pre_valid = 1'b1;
                        pre_item  = make_item(stl_pkg::KindIdent, b, 1'b0);
                        handled   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // start a new token
            if (!handled)
            begin
                mode_next = stl_pkg::LexIdle;
                if (is_ws)
                begin
                    case (ws_mode)
                        stl_pkg::WsRaw:
                        begin
                            fresh_valid = 1'b1;
                            fresh_item  = make_item(stl_pkg::KindChar, b, 1'b1);
                        end
                        stl_pkg::WsSuppress:
                        begin
                        end
                        stl_pkg::WsGroup:
                        begin
                            if (b == stl_pkg::ChSpace)
                            begin
                                mode_next = stl_pkg::LexSpace;
                                cnt_next  = 16'd1;
                            end
                            else
                            begin
                                fresh_valid = 1'b1;
                                fresh_item  = make_item(ws_kind, b, 1'b1);
                            end
                        end
                        default:
                        begin
                            fresh_valid = 1'b1;
                            fresh_item  = make_item(ws_kind, b, 1'b1);
                        end
                    endcase
                end
                else if (is_digit)
                begin
                    mode_next   = stl_pkg::LexNum;
                    fresh_valid = 1'b1;
                    fresh_item  = make_item(stl_pkg::KindNumber, b, 1'b1);
                end
                else if (is_alpha)
                begin
                    mode_next   = stl_pkg::LexIdent;
                    fresh_valid = 1'b1;
                    fresh_item  = make_item(stl_pkg::KindIdent, b, 1'b1);
                end
                else if ((b == stl_pkg::ChDquote) || (b == stl_pkg::ChSquote))
                begin
                    mode_next   = stl_pkg::LexStr;
                    quote_next  = b;
                    esc_next    = 1'b0;
                    fresh_valid = 1'b1;
                    fresh_item  = make_item(stl_pkg::KindString, b, 1'b1);
                end
                else
                begin
                    fresh_valid = 1'b1;
                    fresh_item  = make_item(stl_pkg::KindChar, b, 1'b1);
                end
            end

            // line end closes everything
            if (le)
            begin
                if (mode_next == stl_pkg::LexSpace)
                begin
                    end_valid = 1'b1;
                    end_item  = make_flush(cnt_next);
                end
                mode_next  = stl_pkg::LexIdle;
                quote_next = 8'd0;
                esc_next   = 1'b0;
                cnt_next   = 16'd0;
            end
        end
    end

    // Pack up to two items in order
    always_comb
    begin
        rec = '0;
        if (pre_valid)
        begin
            rec.item_a = pre_item;
            rec.two    = fresh_valid || end_valid;
            rec.item_b = fresh_valid ? fresh_item : end_item;
        end
        else
        begin
            rec.item_a = fresh_valid ? fresh_item : end_item;
            rec.two    = fresh_valid && end_valid;
            rec.item_b = end_item;
        end
        rec.item_a.step_last = !rec.two;
        rec.item_b.step_last = 1'b1;
    end

    assign rec_valid = accept && (pre_valid || fresh_valid || end_valid);

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= stl_pkg::LexIdle;
            quote_reg <= 8'd0;
            esc_reg   <= 1'b0;
            cnt_reg   <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            quote_reg <= quote_next;
            esc_reg   <= esc_next;
            cnt_reg   <= cnt_next;
        end
    end

    // A line end always leaves the lexer idle and clean
    a_line_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && le |=> (mode_reg == stl_pkg::LexIdle) && (cnt_reg == 16'd0)
                         && !esc_reg && (quote_reg == 8'd0))
        else $error("lexer state not cleared at line end");

    // A space run is only open while its count is nonzero
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == stl_pkg::LexSpace) |-> (cnt_reg != 16'd0))
        else $error("open space run with zero count");

endmodule

// File: rtl/core/stl_queue.sv
module stl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  stl_pkg::step_rec_t  wr_rec,
    input  logic                rd_en,
    output stl_pkg::step_rec_t  rd_rec,
    output logic                q_empty,
    output logic                q_full
);

    stl_pkg::step_rec_t                  slot_reg [stl_pkg::QueueDepth];
    logic [stl_pkg::QueuePtrWidth-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [stl_pkg::QueueCntWidth-1:0]   cnt_reg, cnt_next;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == stl_pkg::QueueCntWidth'(stl_pkg::QueueDepth));
    assign rd_rec  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !(rd_en && !q_empty))
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en && !q_empty)
            cnt_next = cnt_reg - 1'b1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en && !q_empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // Record storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("record written into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= stl_pkg::QueueCntWidth'(stl_pkg::QueueDepth))
        else $error("queue count out of range");

endmodule

// File: rtl/core/stl_back.sv
module stl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stl_pkg::step_rec_t   head,
    input  logic                 q_empty,
    input  logic                 pop,
    output logic                 rd_en,
    output stl_pkg::token_out_t  result
);

    logic second_reg;
    logic take;

    assign take   = pop && !q_empty;
    assign result = second_reg ? head.item_b : head.item_a;
    // release the record after its last item
    assign rd_en  = take && (second_reg || !head.two);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else if (take)
            second_reg <= head.two && !second_reg;
    end

    a_second_valid: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> !q_empty && head.two)
        else $error("second item selected without a two-item record");

endmodule

// File: test/tb_top.sv
module tb_top;

    localparam int CycleLimit = 1_000_000;
    localparam int PauseCycles = 8;
    localparam int RandomTarget = 1400;

    logic clk;
    logic rst_n;
    logic push = 1'b0;
    logic full;
    stl_pkg::text_in_t item_bus = '0;
    logic empty;
    logic pop = 1'b0;
    stl_pkg::token_out_t token_bus;
    logic psel;
    logic penable;
    logic pwrite;
    logic [stl_pkg::CfgAddrWidth-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // Text waiting to be sent, and tokens waiting to come out
    stl_pkg::text_in_t text_pending[$];
    stl_pkg::token_out_t token_due[$];
    stl_pkg::token_out_t step_items[$];

    int queued_count = 0;
    int accepted_count = 0;
    int errors = 0;
    int cycle_count = 0;
    int push_wait = 0;
    int pop_wait = 0;
    bit push_taken = 0;
    bit pop_taken = 0;
    bit steady_send = 0;
    bit steady_take = 0;

    // Lexer model state
    logic [1:0] ws_mode = stl_pkg::WsLiteral;
    logic [2:0] lex_state = stl_pkg::LexIdle;
    logic [7:0] quote_ch = 8'h00;
    logic esc_on = 1'b0;
    logic [15:0] run_len = 16'h0;

    source_text_lexer DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item_bus),
        .empty(empty),
        .pop(pop),
        .result(token_bus),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic stl_pkg::token_out_t token_of(input logic [2:0] kind,
                                                     input logic [7:0] b,
                                                     input logic start,
                                                     input logic [15:0] run);
        stl_pkg::token_out_t t;
        t.token_kind = kind;
        t.token_byte = b;
        t.token_start = start;
        t.space_run = run;
        t.step_last = 1'b0;
        return t;
    endfunction

    function automatic int draw_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, 7);
    endfunction

    task automatic clear_line();
        lex_state = stl_pkg::LexIdle;
        quote_ch = 8'h00;
        esc_on = 1'b0;
        run_len = 16'h0;
    endtask

    // Close an open space run: a single space or a counted group
    task automatic close_run();
        if (run_len >= 16'd2)
            step_items.push_back(token_of(stl_pkg::KindGroup, 8'h00, 1'b1, run_len));
        else
            step_items.push_back(token_of(stl_pkg::KindSpace, stl_pkg::ChSpace, 1'b1,
                                          16'h0));
        run_len = 16'h0;
        lex_state = stl_pkg::LexIdle;
    endtask

    // Tokens caused by one text byte, appended to token_due
    task automatic lex_byte(input stl_pkg::text_in_t t);
        logic [7:0] b;
        logic [2:0] ws_kind;
        bit handled;
        b = t.text_byte;
        handled = 0;
        step_items.delete();
        if (lex_state == stl_pkg::LexDrop)
        begin
            if (t.line_end)
                clear_line();
            return;
        end
        if (b == stl_pkg::ChNul)
        begin
            // zero byte closes a run and drops the rest of its line
            if (lex_state == stl_pkg::LexSpace)
                close_run();
            clear_line();
            if (!t.line_end)
                lex_state = stl_pkg::LexDrop;
        end
        else
        begin
            // continue the open token if this byte belongs to it
            case (lex_state)
                stl_pkg::LexSpace:
                    if (b == stl_pkg::ChSpace)
                    begin
                        if (run_len < stl_pkg::SpaceLimit)
                            run_len = run_len + 16'd1;
                        handled = 1;
                    end
                    else
                        close_run();
                stl_pkg::LexStr:
                begin
                    step_items.push_back(token_of(stl_pkg::KindString, b, 1'b0, 16'h0));
                    handled = 1;
                    if (b == stl_pkg::ChBackslash)
                        esc_on = ~esc_on;
                    else if (b == quote_ch && !esc_on)
                    begin
                        lex_state = stl_pkg::LexIdle;
                        quote_ch = 8'h00;
                    end
                    else
                        esc_on = 1'b0;
                end
                stl_pkg::LexNum:
                    if (is_digit(b) || is_alpha(b) || b == stl_pkg::ChDot)
                    begin
                        step_items.push_back(token_of(stl_pkg::KindNumber, b, 1'b0,
                                                      16'h0));
                        handled = 1;
                    end
                stl_pkg::LexIdent:
                    if (is_alpha(b) || b == stl_pkg::ChUnderscore)
                    begin
                        step_items.push_back(token_of(stl_pkg::KindIdent, b, 1'b0,
                                                      16'h0));
                        handled = 1;
                    end
                default:
                    ;
            endcase
            // otherwise the byte starts a new token
            if (!handled)
            begin
                lex_state = stl_pkg::LexIdle;
                if (b == stl_pkg::ChNewline || b == stl_pkg::ChTab || b == stl_pkg::ChSpace)
                begin
                    ws_kind = (b == stl_pkg::ChNewline) ? stl_pkg::KindNewline :
                              (b == stl_pkg::ChTab) ? stl_pkg::KindTab : stl_pkg::KindSpace;
                    case (ws_mode)
                        stl_pkg::WsRaw:
                            step_items.push_back(token_of(stl_pkg::KindChar, b, 1'b1,
                                                          16'h0));
                        stl_pkg::WsSuppress:
                            ;
                        stl_pkg::WsGroup:
                            if (b == stl_pkg::ChSpace)
                            begin
                                lex_state = stl_pkg::LexSpace;
                                run_len = 16'd1;
                            end
                            else
                                step_items.push_back(token_of(ws_kind, b, 1'b1, 16'h0));
                        default:
                            step_items.push_back(token_of(ws_kind, b, 1'b1, 16'h0));
                    endcase
                end
                else if (is_digit(b))
                begin
                    lex_state = stl_pkg::LexNum;
                    step_items.push_back(token_of(stl_pkg::KindNumber, b, 1'b1, 16'h0));
                end
                else if (is_alpha(b))
                begin
                    lex_state = stl_pkg::LexIdent;
                    step_items.push_back(token_of(stl_pkg::KindIdent, b, 1'b1, 16'h0));
                end
                else if (b == stl_pkg::ChDquote || b == stl_pkg::ChSquote)
                begin
                    lex_state = stl_pkg::LexStr;
                    quote_ch = b;
                    esc_on = 1'b0;
                    step_items.push_back(token_of(stl_pkg::KindString, b, 1'b1, 16'h0));
                end
                else
                    step_items.push_back(token_of(stl_pkg::KindChar, b, 1'b1, 16'h0));
            end
            if (t.line_end)
            begin
                if (lex_state == stl_pkg::LexSpace)
                    close_run();
                clear_line();
            end
        end
        if (step_items.size() != 0)
            step_items[step_items.size() - 1].step_last = 1'b1;
        foreach (step_items[i])
            token_due.push_back(step_items[i]);
    endtask

    // Input side: record each transfer and predict its tokens
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            lex_byte(item_bus);
            accepted_count++;
            push_taken = 1;
        end
    end

    // Output side: compare each transfer with the oldest expected token
    always @(posedge clk)
    begin : check_tokens
        stl_pkg::token_out_t want;
        if (rst_n && pop && !empty)
        begin
            pop_taken = 1;
            if (token_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected token, expected none, actual kind %0d byte %h",
                         $time, token_bus.token_kind, token_bus.token_byte,
                         " start %0d run %0d last %0d", token_bus.token_start,
                         token_bus.space_run, token_bus.step_last);
            end
            else
            begin
                want = token_due.pop_front();
                if (token_bus !== want)
                begin
                    errors++;
                    $display("%0t: token mismatch, expected kind %0d byte %h start %0d",
                             $time, want.token_kind, want.token_byte, want.token_start,
                             " run %0d last %0d, actual kind %0d byte %h start %0d",
                             want.space_run, want.step_last, token_bus.token_kind,
                             token_bus.token_byte, token_bus.token_start,
                             " run %0d last %0d", token_bus.space_run, token_bus.step_last);
                end
            end
        end
    end

    // Text driver with a random gap after each transfer
    always @(negedge clk)
    begin
        if (!push || push_taken)
        begin
            push_taken = 0;
            if (push_wait != 0)
            begin
                push <= 1'b0;
                push_wait--;
            end
            else if (text_pending.size() != 0)
            begin
                item_bus <= text_pending.pop_front();
                push <= 1'b1;
                push_wait = draw_wait(steady_send);
            end
            else
                push <= 1'b0;
        end
    end

    // Token receiver with random stalls
    always @(negedge clk)
    begin
        if (!pop || pop_taken)
        begin
            if (pop_taken)
                pop_wait = draw_wait(steady_take);
            pop_taken = 0;
            if (pop_wait != 0)
            begin
                pop <= 1'b0;
                pop_wait--;
            end
            else
                pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input bit le);
        stl_pkg::text_in_t t;
        t.text_byte = b;
        t.line_end = le;
        text_pending.push_back(t);
        queued_count++;
    endtask

    task automatic queue_text(input string s, input bit le);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], le && i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A)) :
                                      8'($urandom_range(8'h41, 8'h5A));
    endfunction

    // One line of token-shaped text; now and then pure noise
    task automatic queue_line(input bit close);
        logic [7:0] line_bytes[$];
        logic [7:0] q;
        string punct;
        int n;
        int sel;
        punct = "+-*/=(){};,<>!#&|.@$";
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                queue_byte(8'($urandom_range(0, 255)),
                           $urandom_range(0, 7) == 0 || (close && k == n - 1));
            return;
        end
        repeat ($urandom_range(1, 6))
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
            begin
                line_bytes.push_back(rand_letter());
                repeat ($urandom_range(0, 6))
                    line_bytes.push_back($urandom_range(0, 4) == 0 ?
                                         stl_pkg::ChUnderscore : rand_letter());
            end
            else if (sel < 35)
            begin
                line_bytes.push_back(8'($urandom_range("0", "9")));
                repeat ($urandom_range(0, 5))
                begin
                    n = $urandom_range(0, 5);
                    line_bytes.push_back(n < 3 ? 8'($urandom_range("0", "9")) :
                                         n < 5 ? rand_letter() : stl_pkg::ChDot);
                end
            end
            else if (sel < 52)
            begin
                // quoted string with escapes, sometimes left open
                q = $urandom_range(0, 1) ? stl_pkg::ChDquote : stl_pkg::ChSquote;
                line_bytes.push_back(q);
                repeat ($urandom_range(0, 6))
                begin
                    n = $urandom_range(0, 99);
                    line_bytes.push_back(n < 40 ? rand_letter() :
                                         n < 55 ? stl_pkg::ChSpace :
                                         n < 75 ? stl_pkg::ChBackslash :
                                         n < 85 ? q :
                                         n < 92 ? (q == stl_pkg::ChDquote ?
                                                   stl_pkg::ChSquote : stl_pkg::ChDquote) :
                                         8'(punct[$urandom_range(0, punct.len() - 1)]));
                end
                if ($urandom_range(0, 4) != 0)
                    line_bytes.push_back(q);
            end
            else if (sel < 70)
            begin
                n = ($urandom_range(0, 49) == 0) ? $urandom_range(6, 300) :
                                                   $urandom_range(1, 5);
                repeat (n)
                    line_bytes.push_back(stl_pkg::ChSpace);
            end
            else if (sel < 77)
                line_bytes.push_back($urandom_range(0, 1) ? stl_pkg::ChTab :
                                                            stl_pkg::ChNewline);
            else if (sel < 90)
                line_bytes.push_back(punct[$urandom_range(0, punct.len() - 1)]);
            else if (sel < 97)
                line_bytes.push_back(8'($urandom_range(1, 255)));
            else
                line_bytes.push_back(stl_pkg::ChNul);
        end
        foreach (line_bytes[k])
            queue_byte(line_bytes[k], close && k == line_bytes.size() - 1);
    endtask

    // Wait until all text is in and every token is out, then let the block go quiet
    task automatic settle();
        while (accepted_count != queued_count || token_due.size() != 0)
            @(negedge clk);
        repeat (PauseCycles) @(negedge clk);
    endtask

    // Register write followed by a read back
    task automatic write_mode(input logic [1:0] m);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= stl_pkg::AddrWhitespaceMode;
        pwdata <= {30'b0, m};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        ws_mode = m;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[1:0] !== m)
        begin
            errors++;
            $display("%0t: whitespace_mode read back, expected %0d, actual %0d",
                     $time, m, prdata[1:0]);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        int random_base;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // literal whitespace, numbers, identifiers, strings, zero bytes
        write_mode(stl_pkg::WsLiteral);
        queue_text("ab_ 1x.\t+", 1'b1);
        queue_text("\"\\\"\\\\\"q", 1'b1);
        queue_text("'a", 1'b1);
        queue_text("a", 1'b0);
        queue_byte(stl_pkg::ChNul, 1'b0);
        queue_text("b\n", 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(stl_pkg::ChNul, 1'b1);
        settle();
        write_mode(stl_pkg::WsRaw);
        queue_text(" \n\tk", 1'b1);
        settle();
        write_mode(stl_pkg::WsSuppress);
        queue_text("\t x\n", 1'b1);
        settle();
        // grouped spaces, closed by a byte, by line end and by a zero byte
        write_mode(stl_pkg::WsGroup);
        queue_text("a  b c\n  ", 1'b1);
        queue_text(" ", 1'b0);
        queue_byte(stl_pkg::ChNul, 1'b1);
        queue_text("  ", 1'b0);
        settle();
        // open run survives a mode change
        write_mode(stl_pkg::WsRaw);
        queue_text("z", 1'b1);
        settle();

        // random phases, each under its own whitespace mode
        random_base = queued_count;
        while (queued_count - random_base < RandomTarget)
        begin
            write_mode(2'($urandom_range(0, 3)));
            steady_send = ($urandom_range(0, 3) == 0);
            steady_take = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(3, 12))
                queue_line(1'b1);
            if ($urandom_range(0, 2) == 0)
                queue_line(1'b0);
            settle();
        end

        if (errors == 0 && token_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
